[rtl/vdm_pkg.sv]
// Shared types and constants for the vector distance metric block.
package vdm_pkg;

   localparam int ELEM_W     = 16;
   localparam int ACC_W      = 48;
   localparam int ROOT_W     = ACC_W / 2;
   localparam int OUT_W      = 32;
   localparam int OUT_FRAC   = 15;
   localparam int NUM_W      = ACC_W + OUT_FRAC;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = NUM_W;
   localparam int CNT_W      = 6;

   localparam logic [1:0] METRIC_EUCLIDEAN = 2'd0;
   localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
   localparam logic [1:0] METRIC_COSINE    = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO    = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   localparam logic [1:0] SEL_MAIN   = 2'd0;
   localparam logic [1:0] SEL_NORM_A = 2'd1;
   localparam logic [1:0] SEL_NORM_B = 2'd2;

   localparam logic [2:0] ADDR_METRIC = 3'd0;

   typedef struct packed {
      logic       acc;
      logic       last;
      logic       sq_step;
      logic       sq_first;
      logic [1:0] sq_sel;
      logic       save_ra;
      logic       mul;
      logic       div_step;
      logic       div_first;
      logic       res_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] metric;
      logic       mag_zero;
   } stat_type;

endpackage

[rtl/vdm_ctrl.sv]
// Sequencer for accumulation, square roots, multiply, divide and result hand-off.
module vdm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last_elem,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  vdm_pkg::stat_type stat,
   output vdm_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_ACCUM, ST_ROUTE, ST_SQ_MAIN, ST_SQ_A, ST_SQ_B, ST_MUL, ST_DIV, ST_RESULT
   } state_type;

   state_type                  state_ff, state_in;
   logic [vdm_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       sq_done, div_done;

   assign sq_done   = cnt_ff == vdm_pkg::CNT_W'(vdm_pkg::SQRT_STEPS - 1);
   assign div_done  = cnt_ff == vdm_pkg::CNT_W'(vdm_pkg::DIV_STEPS - 1);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            cmd.acc   = req_valid;
            cmd.last  = req_last_elem;
            if (req_valid && req_last_elem) begin
               state_in = ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            cnt_in = '0;
            case (stat.metric)
               vdm_pkg::METRIC_EUCLIDEAN: state_in = ST_SQ_MAIN;
               vdm_pkg::METRIC_COSINE:    state_in = ST_SQ_A;
               default:                   state_in = ST_RESULT;
            endcase
         end
         ST_SQ_MAIN, ST_SQ_A, ST_SQ_B: begin
            cmd.sq_step  = 1'b1;
            cmd.sq_first = cnt_ff == '0;
            cmd.sq_sel   = (state_ff == ST_SQ_MAIN) ? vdm_pkg::SEL_MAIN :
                           (state_ff == ST_SQ_A) ? vdm_pkg::SEL_NORM_A : vdm_pkg::SEL_NORM_B;
            cmd.save_ra  = (state_ff == ST_SQ_B) && (cnt_ff == '0);
            cnt_in       = cnt_ff + 1'b1;
            if (sq_done) begin
               cnt_in = '0;
               case (state_ff)
                  ST_SQ_A: state_in = ST_SQ_B;
                  ST_SQ_B: state_in = ST_MUL;
                  default: state_in = ST_RESULT;
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.mag_zero) begin
               state_in = ST_RESULT;
            end else begin
               cmd.div_step  = 1'b1;
               cmd.div_first = cnt_ff == '0;
               cnt_in        = cnt_ff + 1'b1;
               if (div_done) begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/vdm_datapath.sv]
// Accumulators, shared square root unit, multiplier, divider and result register.
module vdm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [vdm_pkg::ELEM_W-1:0] req_elem_a,
   input  logic signed [vdm_pkg::ELEM_W-1:0] req_elem_b,
   input  logic [1:0]                        cfg_metric,
   input  vdm_pkg::cmd_type                  cmd,
   output vdm_pkg::stat_type                 stat,
   output logic [vdm_pkg::OUT_W-1:0]         rsp_metric_value,
   output logic [1:0]                        rsp_status
);

   localparam int AW = vdm_pkg::ACC_W;
   localparam int RW = vdm_pkg::ROOT_W;
   localparam int NW = vdm_pkg::NUM_W;
   localparam logic [AW-1:0]  UMAX = {AW{1'b1}};
   localparam logic [AW:0]    SMAX = {2'b00, {(AW-1){1'b1}}};
   localparam logic [AW:0]    SMIN = {2'b11, {(AW-1){1'b0}}};
   localparam logic [vdm_pkg::OUT_W-1:0] OMAX = {1'b0, {(vdm_pkg::OUT_W-1){1'b1}}};
   localparam logic [vdm_pkg::OUT_W-1:0] OMIN = {1'b1, {(vdm_pkg::OUT_W-1){1'b0}}};

   logic signed [AW:0]   main_ff, main_in;
   logic [AW-1:0]        na_ff, na_in, nb_ff, nb_in;
   logic signed [AW:0]   wmain_ff;
   logic [AW-1:0]        wna_ff, wnb_ff;
   logic [1:0]           metric_ff;
   logic [AW-1:0]        sq_src_ff, sq_src_in;
   logic [RW+1:0]        sq_rem_ff, sq_rem_in;
   logic [RW-1:0]        root_ff, root_in, ra_ff;
   logic [AW-1:0]        mag_ff;
   logic [NW-1:0]        num_ff, num_in, q_ff, q_in;
   logic [AW-1:0]        drem_ff, drem_in;
   logic [vdm_pkg::OUT_W-1:0] value_ff, value_in;
   logic [1:0]           status_ff, status_in;

   logic signed [vdm_pkg::ELEM_W:0]     diff;
   logic [vdm_pkg::ELEM_W:0]            adiff;
   logic [2*vdm_pkg::ELEM_W+1:0]        sqd;
   logic signed [2*vdm_pkg::ELEM_W-1:0] paa, pbb, pab;
   logic [AW-1:0]        main_pos, uterm;
   logic [AW:0]          usum, nasum, nbsum;
   logic signed [AW:0]   clampd, dsum, dclamp, wclamp;
   logic [AW-1:0]        udot;
   logic [AW-1:0]        sq_sel_src, cur_src;
   logic [RW+1:0]        cur_rem;
   logic [RW-1:0]        cur_root;
   logic [RW+3:0]        rem_sh, trial;
   logic                 sq_ge;
   logic [NW-1:0]        cur_num, cur_q;
   logic [AW-1:0]        cur_drem;
   logic [AW:0]          drem_sh;
   logic                 d_ge;

   always_comb begin
      diff  = (vdm_pkg::ELEM_W+1)'(req_elem_a) - (vdm_pkg::ELEM_W+1)'(req_elem_b);
      adiff = diff[vdm_pkg::ELEM_W] ? (vdm_pkg::ELEM_W+1)'(-diff) : diff;
      sqd   = (2*vdm_pkg::ELEM_W+2)'(adiff) * (2*vdm_pkg::ELEM_W+2)'(adiff);
      paa   = req_elem_a * req_elem_a;
      pbb   = req_elem_b * req_elem_b;
      pab   = req_elem_a * req_elem_b;

      main_pos = main_ff[AW] ? '0 : main_ff[AW-1:0];
      uterm    = (cfg_metric == vdm_pkg::METRIC_EUCLIDEAN) ? AW'(sqd) : AW'(adiff);
      usum     = {1'b0, main_pos} + {1'b0, uterm};
      nasum    = {1'b0, na_ff} + (AW+1)'(unsigned'(paa));
      nbsum    = {1'b0, nb_ff} + (AW+1)'(unsigned'(pbb));
      clampd   = (!main_ff[AW] && main_ff[AW-1]) ? SMAX : main_ff;
      dsum     = clampd + (AW+1)'(pab);
      dclamp   = (dsum > signed'(SMAX)) ? SMAX : ((dsum < signed'(SMIN)) ? SMIN : dsum);

      case (cfg_metric)
         vdm_pkg::METRIC_EUCLIDEAN, vdm_pkg::METRIC_MANHATTAN:
            main_in = {1'b0, usum[AW] ? UMAX : usum[AW-1:0]};
         vdm_pkg::METRIC_COSINE: main_in = dclamp;
         default:                main_in = main_ff;
      endcase
      na_in = nasum[AW] ? UMAX : nasum[AW-1:0];
      nb_in = nbsum[AW] ? UMAX : nbsum[AW-1:0];

      case (cmd.sq_sel)
         vdm_pkg::SEL_MAIN:   sq_sel_src = wmain_ff[AW] ? '0 : wmain_ff[AW-1:0];
         vdm_pkg::SEL_NORM_A: sq_sel_src = wna_ff;
         default:             sq_sel_src = wnb_ff;
      endcase
      cur_src   = cmd.sq_first ? sq_sel_src : sq_src_ff;
      cur_rem   = cmd.sq_first ? '0 : sq_rem_ff;
      cur_root  = cmd.sq_first ? '0 : root_ff;
      rem_sh    = {cur_rem, cur_src[AW-1:AW-2]};
      trial     = {2'b00, cur_root, 2'b01};
      sq_ge     = rem_sh >= trial;
      sq_rem_in = (RW+2)'(sq_ge ? rem_sh - trial : rem_sh);
      root_in   = {cur_root[RW-2:0], sq_ge};
      sq_src_in = {cur_src[AW-3:0], 2'b00};

      wclamp   = (!wmain_ff[AW] && wmain_ff[AW-1]) ? SMAX : wmain_ff;
      udot     = wclamp[AW] ? AW'(-wclamp) : wclamp[AW-1:0];
      cur_num  = cmd.div_first ? {udot, {vdm_pkg::OUT_FRAC{1'b0}}} : num_ff;
      cur_drem = cmd.div_first ? '0 : drem_ff;
      cur_q    = cmd.div_first ? '0 : q_ff;
      drem_sh  = {cur_drem, cur_num[NW-1]};
      d_ge     = drem_sh >= {1'b0, mag_ff};
      drem_in  = AW'(d_ge ? drem_sh - {1'b0, mag_ff} : drem_sh);
      q_in     = {cur_q[NW-2:0], d_ge};
      num_in   = {cur_num[NW-2:0], 1'b0};

      value_in  = '0;
      status_in = vdm_pkg::STATUS_OK;
      case (metric_ff)
         vdm_pkg::METRIC_EUCLIDEAN: value_in = vdm_pkg::OUT_W'(root_ff);
         vdm_pkg::METRIC_MANHATTAN: begin
            if (wmain_ff[AW]) begin
               value_in = '0;
            end else if (wmain_ff[AW-1:0] > AW'(OMAX)) begin
               value_in = OMAX;
            end else begin
               value_in = wmain_ff[vdm_pkg::OUT_W-1:0];
            end
         end
         vdm_pkg::METRIC_COSINE: begin
            if (mag_ff == '0) begin
               status_in = vdm_pkg::STATUS_ZERO;
            end else if (wclamp[AW]) begin
               value_in = (q_ff > NW'(OMIN)) ? OMIN : vdm_pkg::OUT_W'(-q_ff);
            end else begin
               value_in = (q_ff > NW'(OMAX)) ? OMAX : q_ff[vdm_pkg::OUT_W-1:0];
            end
         end
         default: status_in = vdm_pkg::STATUS_UNKNOWN;
      endcase
   end

   assign stat.metric   = metric_ff;
   assign stat.mag_zero = mag_ff == '0;
   assign rsp_metric_value = value_ff;
   assign rsp_status       = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff <= '0;
         na_ff   <= '0;
         nb_ff   <= '0;
      end else if (cmd.acc) begin
         if (cmd.last) begin
            main_ff <= '0;
            na_ff   <= '0;
            nb_ff   <= '0;
         end else begin
            main_ff <= main_in;
            na_ff   <= na_in;
            nb_ff   <= nb_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc && cmd.last) begin
         wmain_ff  <= main_in;
         wna_ff    <= na_in;
         wnb_ff    <= nb_in;
         metric_ff <= cfg_metric;
      end
      if (cmd.sq_step) begin
         sq_src_ff <= sq_src_in;
         sq_rem_ff <= sq_rem_in;
         root_ff   <= root_in;
      end
      if (cmd.save_ra) begin
         ra_ff <= root_ff;
      end
      if (cmd.mul) begin
         mag_ff <= ra_ff * root_ff;
      end
      if (cmd.div_step) begin
         num_ff  <= num_in;
         drem_ff <= drem_in;
         q_ff    <= q_in;
      end
      if (cmd.res_load) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

endmodule

[rtl/vector_distance_metric.sv]
// Top level of the vector distance metric block: register port and unit wiring.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_elem_a, req_elem_b, req_last_elem
//   rsp      out        rsp_valid/rsp_ready  rsp_metric_value, rsp_status
//   csr      in         APB, pready high     metric_select at byte 0
//
// Element pairs transfer one per cycle into the accumulators while the block is accumulating.
// After a last pair: manhattan and unknown pass through routing to the result register,
// euclidean runs a 24-step root first; cosine two roots, a multiply and a 63-step divide.
// Input is held off during that work; a pending result stalls only the next finish.
// Reset is synchronous and clears the accumulators, metric and valid flags.
module vector_distance_metric (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [vdm_pkg::ELEM_W-1:0] req_elem_a,
   input  logic signed [vdm_pkg::ELEM_W-1:0] req_elem_b,
   input  logic                              req_last_elem,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vdm_pkg::OUT_W-1:0]  rsp_metric_value,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [1:0]        metric_ff;
   vdm_pkg::cmd_type  cmd;
   vdm_pkg::stat_type stat;
   logic [vdm_pkg::OUT_W-1:0] value;

   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr == vdm_pkg::ADDR_METRIC) ? {30'b0, metric_ff} : '0;
   assign rsp_metric_value = signed'(value);

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= vdm_pkg::METRIC_EUCLIDEAN;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         metric_ff <= csr_pwdata[1:0];
      end
   end

   vdm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_elem (req_last_elem),
      .req_ready     (req_ready),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .stat          (stat),
      .cmd           (cmd)
   );

   vdm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_elem_a       (req_elem_a),
      .req_elem_b       (req_elem_b),
      .cfg_metric       (metric_ff),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_metric_value (value),
      .rsp_status       (rsp_status)
   );

endmodule

[rtl/vdm_checker.sv]
// Port-level assertions for the vector distance metric block, with bind.
module vdm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_metric_value,
   input logic [1:0]  rsp_status,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_metric_value))
      else $error("result dropped or changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != vdm_pkg::STATUS_OK |-> rsp_metric_value == '0)
      else $error("error result carries nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == vdm_pkg::STATUS_OK || rsp_status == vdm_pkg::STATUS_ZERO
                    || rsp_status == vdm_pkg::STATUS_UNKNOWN)
      else $error("undefined status code");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("register port not ready");

endmodule

bind vector_distance_metric vdm_checker u_vdm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_metric_value (rsp_metric_value),
   .rsp_status       (rsp_status),
   .csr_pready       (csr_pready)
);

[tb/tb_vector_distance_metric.sv]
// Self-checking testbench for vector_distance_metric: random streams, predicted results.
`timescale 1ns / 100ps

module tb_vector_distance_metric;

   localparam longint ACC_UMAX   = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint ACC_SMAX   = 64'h0000_7FFF_FFFF_FFFF;
   localparam longint ACC_SMIN   = -64'sh0000_8000_0000_0000;
   localparam longint VAL_MAX    = 64'sd2147483647;
   localparam int     CYCLE_LIMIT = 2000000;
   localparam int     DRAIN_WAIT  = 200;

   typedef struct {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic               last;
   } pair_type;

   typedef struct {
      logic signed [31:0] value;
      logic [1:0]         status;
   } metric_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_elem_a = '0;
   logic signed [15:0] req_elem_b = '0;
   logic req_last_elem = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_metric_value;
   logic [1:0] rsp_status;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   vector_distance_metric u_top (.*);

   pair_type   pair_q[$];
   metric_type metric_q[$];
   logic [1:0] cur_metric = vdm_pkg::METRIC_EUCLIDEAN;
   longint dist_acc = 0, norm_a = 0, norm_b = 0;
   int errors = 0, pairs_sent = 0, results_seen = 0, cycles = 0;
   int src_gap = 0, sink_gap = 0, hold_cnt = 0;
   bit quiet = 0, hold_done = 0, hold_on = 0;
   int counts[4] = '{0, 0, 0, 0};

   initial forever #1 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, bt;
      r = 0;
      bt = 64'h4000_0000_0000_0000;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return r;
   endfunction

   function automatic longint sat_uadd(longint acc, longint unsigned term);
      longint unsigned s;
      s = acc < 0 ? 0 : acc;
      if (term > longint'(ACC_UMAX) - s) return ACC_UMAX;
      return s + term;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic bit predict_metric(pair_type p, output metric_type res);
      longint a, b, d, c, dot, val;
      longint unsigned ad, sq, ra, rb, mag, ud, q, s;
      a = p.a;
      b = p.b;
      d = a - b;
      ad = d < 0 ? -d : d;
      val = 0;
      res.status = vdm_pkg::STATUS_OK;
      norm_a = sat_uadd(norm_a, a * a);
      norm_b = sat_uadd(norm_b, b * b);
      case (cur_metric)
         vdm_pkg::METRIC_EUCLIDEAN: begin
            sq = (ad > 64'hFF_FFFF) ? ACC_UMAX : ad * ad;
            dist_acc = sat_uadd(dist_acc, sq);
         end
         vdm_pkg::METRIC_MANHATTAN: dist_acc = sat_uadd(dist_acc, ad);
         vdm_pkg::METRIC_COSINE: begin
            c = clamp(dist_acc, ACC_SMIN, ACC_SMAX);
            dist_acc = clamp(c + a * b, ACC_SMIN, ACC_SMAX);
         end
         default: ;
      endcase
      if (!p.last) return 0;
      if (cur_metric == vdm_pkg::METRIC_EUCLIDEAN || cur_metric == vdm_pkg::METRIC_MANHATTAN)
      begin
         s = dist_acc < 0 ? 0 : dist_acc;
         if (cur_metric == vdm_pkg::METRIC_EUCLIDEAN) s = int_sqrt(s);
         val = s > VAL_MAX ? VAL_MAX : s;
      end else if (cur_metric == vdm_pkg::METRIC_COSINE) begin
         ra = int_sqrt(norm_a);
         rb = int_sqrt(norm_b);
         mag = ra * rb;
         if (mag == 0) begin
            res.status = vdm_pkg::STATUS_ZERO;
         end else begin
            dot = clamp(dist_acc, ACC_SMIN, ACC_SMAX);
            ud = dot < 0 ? -dot : dot;
            q = (ud << vdm_pkg::OUT_FRAC) / mag;
            if (dot < 0) val = (q > VAL_MAX + 1) ? -VAL_MAX - 1 : -longint'(q);
            else val = (q > VAL_MAX) ? VAL_MAX : q;
         end
      end else begin
         res.status = vdm_pkg::STATUS_UNKNOWN;
      end
      res.value = val[31:0];
      counts[cur_metric]++;
      dist_acc = 0;
      norm_a = 0;
      norm_b = 0;
      return 1;
   endfunction

   always @(posedge clock) begin
      pair_type p;
      metric_type m;
      bit take;
      cycles <= cycles + 1;
      if (!reset) begin
         take = req_valid && req_ready;
         if (take) begin
            p.a = req_elem_a;
            p.b = req_elem_b;
            p.last = req_last_elem;
            pairs_sent++;
            if (predict_metric(p, m)) metric_q.push_back(m);
         end
         if (!req_valid || take) begin
            if (src_gap > 0) begin
               src_gap--;
               req_valid <= 0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
               src_gap = $urandom_range(0, 5);
               req_valid <= 0;
            end else if (pair_q.size() > 0) begin
               p = pair_q.pop_front();
               req_elem_a <= p.a;
               req_elem_b <= p.b;
               req_last_elem <= p.last;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // hold results off for a long stretch once, so the block backs up
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && pairs_sent >= 400) begin
            hold_done <= 1;
            hold_cnt <= 600;
            hold_on <= 1;
         end else if (hold_cnt > 1) begin
            hold_cnt <= hold_cnt - 1;
         end else begin
            hold_cnt <= 0;
            hold_on <= 0;
         end
      end
   end

   always @(posedge clock) begin
      metric_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (metric_q.size() == 0) begin
               $display("%0t: unexpected result value %0d status %0d", $time,
                        rsp_metric_value, rsp_status);
               errors++;
            end else begin
               e = metric_q.pop_front();
               if (rsp_metric_value !== e.value) begin
                  $display("%0t: metric_value expected %0d actual %0d", $time, e.value,
                           rsp_metric_value);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_status);
                  errors++;
               end
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_ready <= 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 5);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= !hold_on;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic add_pair(int a, int b, bit last);
      pair_type p;
      p.a = 16'(a);
      p.b = 16'(b);
      p.last = last;
      pair_q.push_back(p);
   endtask

   function automatic int rand_elem();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return $signed(16'($urandom()));
      endcase
   endfunction

   task automatic add_vector(int len, int kind);
      int a, b;
      for (int i = 0; i < len; i++) begin
         a = rand_elem();
         b = rand_elem();
         case (kind)
            1: a = 0;
            2: b = 0;
            3: b = a;
            4: b = -a;
            default: ;
         endcase
         add_pair(a, b, i == len - 1);
      end
   endtask

   task automatic set_metric(logic [1:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= vdm_pkg::ADDR_METRIC;
      csr_pwdata <= {30'($urandom_range(0, 32'h3FFF_FFFF)), val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      cur_metric = val;
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic drain();
      while (pair_q.size() > 0 || req_valid || metric_q.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      int budget, len;
      logic [1:0] m;
      repeat (4) @(posedge clock);
      reset <= 0;
      for (int ph = 0; ph < 9; ph++) begin
         m = ph < 4 ? ph[1:0] : 2'($urandom_range(0, 3));
         if (ph == 8) m = vdm_pkg::METRIC_COSINE;
         set_metric(m);
         if (ph < 4) begin
            add_pair(32767, -32768, 1);
            add_pair(-32768, -32768, 1);
            add_pair(-32768, 32767, 0);
            add_pair(32767, 32767, 1);
            add_pair(0, 0, 1);
         end
         if (ph == 8) quiet = 1;
         budget = 175;
         while (budget > 0) begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(9, 40) : $urandom_range(1, 8);
            add_vector(len, $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
            budget -= len;
         end
         // sometimes leave a partial vector so the next metric mixes into it
         if ($urandom_range(0, 1)) add_vector(3, 0);
         if (pair_q.size() > 0 && !pair_q[$].last) pair_q.delete(pair_q.size() - 1);
         if ($urandom_range(0, 1)) add_pair(rand_elem(), rand_elem(), 0);
         drain();
      end
      add_pair(1, 2, 1);
      drain();
      $display("Sent %0d pairs, checked %0d results (euclid %0d manh %0d cos %0d unknown %0d)",
               pairs_sent, results_seen, counts[0], counts[1], counts[2], counts[3]);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/vdm_pkg.sv
rtl/vdm_ctrl.sv
rtl/vdm_datapath.sv
rtl/vector_distance_metric.sv
rtl/vdm_checker.sv
tb/tb_vector_distance_metric.sv
